FILE: sv/p1305_pkg.sv
// Shared types and constants for the Poly1305 authenticator.
`default_nettype none
package p1305_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AccW   = 131;
  localparam int unsigned ProdW  = 256;
  localparam int unsigned ColW   = 67;

  // r clamp mask, little-endian 128-bit value
  localparam logic [127:0] RClamp = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
  // prime 2^130 - 5
  localparam logic [AccW-1:0] Prime = {1'b0, 130'h3_ffffffff_ffffffff_ffffffff_fffffffb};

  localparam logic [1:0] RegRLow  = 2'd0;
  localparam logic [1:0] RegRHigh = 2'd1;
  localparam logic [1:0] RegSLow  = 2'd2;
  localparam logic [1:0] RegSHigh = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_RED1 = 8'b0000_1000,
    S_RED2 = 8'b0001_0000,
    S_FIN1 = 8'b0010_0000,
    S_FIN2 = 8'b0100_0000,
    S_FIN3 = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

FILE: sv/p1305_fold.sv
// Modular fold: value mod-reduced to below 2^131 using 2^130 = 5 (mod p).
`default_nettype none
module p1305_fold (
  input  wire logic [p1305_pkg::ProdW-1:0] value_in,
  output logic      [p1305_pkg::AccW-1:0]  value_out
);
  logic [129:0] lo;
  logic [125:0] hi;

  // split at bit 130 and add high part times five
  always_comb begin
    lo = value_in[129:0];
    hi = value_in[255:130];
    value_out = {1'b0, lo} + {5'b0, hi} + {3'b0, hi, 2'b00};
  end
endmodule
`default_nettype wire

FILE: sv/poly1305_mac.sv
// Poly1305 one-time authenticator top level with iterative 32x32 multiplier.
// A full or short block passes through load, the multiply steps and two folds;
// a last item adds a final reduction and the pad addition before the tag beat.
// The single 32x32 multiplier works on one item at a time: a new item is taken only once the last is through;
// an empty item skips the multiply, and a tag waits while the last one is held.
// Reset clears the key registers, accumulator, sequencer and output valid.
`default_nettype none
module poly1305_mac (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] block_low,
  input  wire logic [63:0] block_high,
  input  wire logic [4:0]  byte_count,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      tag_low,
  output logic [63:0]      tag_high
);
  p1305_pkg::state_t state;
  logic [63:0] r_lo, r_hi, s_lo, s_hi;
  logic [p1305_pkg::AccW-1:0]  h;
  logic [128:0]                msg;
  logic                        do_abs, last;
  logic [p1305_pkg::ProdW-1:0] prod;
  logic [p1305_pkg::ColW-1:0]  col_acc;
  logic [2:0]                  col;
  logic [1:0]                  j;

  logic [128:0] msg_next;
  logic [4:0]   n;
  logic [127:0] blk, r_cl;
  logic [159:0] h_ext;
  logic [2:0]   i;
  logic [31:0]  h_word, r_word;
  logic [63:0]  pp;
  logic [p1305_pkg::ColW-1:0]  col_sum;
  logic [1:0]   j_top;
  logic         col_end;
  logic [p1305_pkg::ProdW-1:0] fold_in;
  logic [p1305_pkg::AccW-1:0]  fold_out;
  logic [127:0] tag_sum;
  logic         tag_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == p1305_pkg::S_IDLE);
  assign tag_load  = (state == p1305_pkg::S_FIN3) && (!out_valid || out_ready);

  // pad the incoming block per byte count
  always_comb begin
    n = (byte_count > 5'd16) ? 5'd16 : byte_count;
    blk = {block_high, block_low};
    msg_next = '0;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < n) msg_next[b*8 +: 8] = blk[b*8 +: 8];
      else if (5'(b) == n) msg_next[b*8 +: 8] = 8'h01;
    end
    msg_next[128] = (n == 5'd16);
  end

  // multiplier operand select and column accumulate
  always_comb begin
    r_cl    = {r_hi, r_lo} & p1305_pkg::RClamp;
    h_ext   = {29'b0, h};
    i       = col - {1'b0, j};
    h_word  = h_ext[i*32 +: 32];
    r_word  = r_cl[j*32 +: 32];
    pp      = h_word * r_word;
    col_sum = col_acc + {3'b0, pp};
    j_top   = (col > 3'd3) ? 2'd3 : col[1:0];
    col_end = (j == j_top);
    fold_in = state[3] ? prod : {125'b0, h};
    tag_sum = h[127:0] + {s_hi, s_lo};
  end

  p1305_fold u_fold (
    .value_in  (fold_in),
    .value_out (fold_out)
  );

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_lo <= '0; r_hi <= '0; s_lo <= '0; s_hi <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        p1305_pkg::RegRLow:  r_lo <= cfg_data;
        p1305_pkg::RegRHigh: r_hi <= cfg_data;
        p1305_pkg::RegSLow:  s_lo <= cfg_data;
        p1305_pkg::RegSHigh: s_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register: load a fresh tag, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tag_load) begin
      tag_low   <= tag_sum[63:0];
      tag_high  <= tag_sum[127:64];
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= p1305_pkg::S_IDLE;
      h         <= '0;
      col       <= '0;
      j         <= '0;
      col_acc   <= '0;
    end else begin
      unique case (state)
        p1305_pkg::S_IDLE: begin
          if (in_valid) begin
            msg    <= msg_next;
            do_abs <= (n != 5'd0);
            last   <= is_last;
            state  <= p1305_pkg::S_LOAD;
          end
        end
        p1305_pkg::S_LOAD: begin
          col     <= '0;
          j       <= '0;
          col_acc <= '0;
          if (do_abs) begin
            h     <= h + {2'b0, msg};
            state <= p1305_pkg::S_MUL;
          end else begin
            state <= last ? p1305_pkg::S_FIN1 : p1305_pkg::S_IDLE;
          end
        end
        p1305_pkg::S_MUL: begin
          if (col_end) begin
            prod[col*32 +: 32] <= col_sum[31:0];
            col_acc <= {32'b0, col_sum[p1305_pkg::ColW-1:32]};
            col     <= col + 3'd1;
            j       <= (col >= 3'd3) ? 2'(col - 3'd3) : 2'd0;
            if (col == 3'd7) state <= p1305_pkg::S_RED1;
          end else begin
            col_acc <= col_sum;
            j       <= j + 2'd1;
          end
        end
        p1305_pkg::S_RED1: begin
          h     <= fold_out;
          state <= p1305_pkg::S_RED2;
        end
        p1305_pkg::S_RED2: begin
          h     <= fold_out;
          state <= last ? p1305_pkg::S_FIN1 : p1305_pkg::S_IDLE;
        end
        p1305_pkg::S_FIN1: begin
          h     <= fold_out;
          state <= p1305_pkg::S_FIN2;
        end
        p1305_pkg::S_FIN2: begin
          if (h >= p1305_pkg::Prime) h <= h - p1305_pkg::Prime;
          state <= p1305_pkg::S_FIN3;
        end
        p1305_pkg::S_FIN3: begin
          // hold until the output register is free
          if (tag_load) begin
            h     <= '0;
            state <= p1305_pkg::S_IDLE;
          end
        end
        default: state <= p1305_pkg::S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/p1305_check.sv
// Port-level checker for the Poly1305 authenticator, bound to the top level.
`default_nettype none
module p1305_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] tag_low,
  input wire logic [63:0] tag_high
);
  // no tag beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("tag valid after reset");

  // a stalled tag holds
  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tag_low) && $stable(tag_high))
    else $error("tag changed while stalled");

  // accepting a block makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a fresh tag needs an earlier accepted block
  a_tag_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready || $past(!in_ready))
    else $error("tag without work");
endmodule

bind poly1305_mac p1305_check u_p1305_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .tag_low   (tag_low),
  .tag_high  (tag_high)
);
`default_nettype wire
